FILE: sv/bld_pkg.sv
package bld_pkg;

  // register stages: four arithmetic stages, then four divider stages
  localparam int NFRONT = 4;
  localparam int NDIV   = 4;
  localparam int NSTG   = NFRONT + NDIV;

  localparam logic [7:0] FULL = 8'hFF;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_WADD = 3'd1,
    OP_MUL  = 3'd2,
    OP_AMUL = 3'd3,
    OP_COMP = 3'd4
  } op_t;

  // per-stage load enables, shared by every channel
  typedef struct packed {
    logic [NDIV-1:0]   div;
    logic [NFRONT-1:0] front;
  } stg_en_t;

  // floor(v/255), exact for v <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? FULL : v[7:0];
  endfunction

endpackage

FILE: sv/bld_div.sv
module bld_div
  import bld_pkg::*;
(
  input  logic                clk,
  input  logic [NDIV-1:0]     en,
  input  logic [15:0]         num,
  input  logic [7:0]          den,
  input  logic                use_quo,
  input  logic [7:0]          res,
  output logic [7:0]          out_val
);

  // restoring division, two quotient bits per stage; quotient fits 8 bits
  logic [15:0] rem_r [0:NDIV-2];
  logic [7:0]  den_r [0:NDIV-1];
  logic [7:0]  quo_r [0:NDIV-1];
  logic        use_r [0:NDIV-1];
  logic [7:0]  res_r [0:NDIV-1];

  for (genvar g = 0; g < NDIV; g++) begin : g_stg
    localparam int B_HI = 7 - 2 * g;
    localparam int B_LO = B_HI - 1;

    logic [15:0] rin, dsh_hi, dsh_lo, rem_mid, rem_nxt;
    logic [7:0]  din, qin, quo_mid, quo_nxt, resin;
    logic        uin;

    if (g == 0) begin : g_first
      assign rin   = num;
      assign din   = den;
      assign qin   = 8'd0;
      assign uin   = use_quo;
      assign resin = res;
    end else begin : g_next
      assign rin   = rem_r[g-1];
      assign din   = den_r[g-1];
      assign qin   = quo_r[g-1];
      assign uin   = use_r[g-1];
      assign resin = res_r[g-1];
    end

    always_comb begin
      dsh_hi  = {8'd0, din} << B_HI;
      dsh_lo  = {8'd0, din} << B_LO;
      rem_mid = rin;
      quo_mid = qin;
      if (rin >= dsh_hi) begin
        rem_mid       = rin - dsh_hi;
        quo_mid[B_HI] = 1'b1;
      end
      rem_nxt = rem_mid;
      quo_nxt = quo_mid;
      if (rem_mid >= dsh_lo) begin
        rem_nxt       = rem_mid - dsh_lo;
        quo_nxt[B_LO] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        den_r[g] <= din;
        quo_r[g] <= quo_nxt;
        use_r[g] <= uin;
        res_r[g] <= resin;
      end
    end

    if (g < NDIV - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[g]) begin
          rem_r[g] <= rem_nxt;
        end
      end
    end
  end

  assign out_val = use_r[NDIV-1] ? quo_r[NDIV-1] : res_r[NDIV-1];

endmodule

FILE: sv/bld_chan.sv
module bld_chan
  import bld_pkg::*;
(
  input  logic        clk,
  input  stg_en_t     en,
  input  logic [2:0]  op,
  input  logic [7:0]  x,
  input  logic [7:0]  y,
  input  logic [7:0]  p,
  input  logic [7:0]  q,
  input  logic [7:0]  oa_c,
  output logic [7:0]  out_val
);

  // stage a: first products
  logic [2:0]  op_a_r, op_b_r, op_c_r;
  logic [7:0]  p_a_r, p_b_r;
  logic [15:0] m0_a_r, m1_a_r;
  logic [7:0]  res_a_r, res_b_r, res_c_r, res_d_r;
  logic [7:0]  d0_b_r, d1_b_r, d0_c_r;
  logic [15:0] m2_c_r;
  logic [15:0] num_d_r;
  logic [7:0]  den_d_r;
  logic        use_d_r;

  logic [7:0]  ma, mb, mc, md;
  logic [15:0] m0_nxt, m1_nxt;
  logic [7:0]  res_a_nxt;

  always_comb begin
    ma = x;
    mb = p;
    mc = y;
    md = q;
    case (op)
      OP_MUL: begin
        mb = y;
      end
      OP_AMUL: begin
        // 255 - v is the bitwise inverse for 8 bits
        ma = ~x;
        mc = ~y;
      end
      default: begin
      end
    endcase
    m0_nxt    = 16'(ma) * 16'(mb);
    m1_nxt    = 16'(mc) * 16'(md);
    res_a_nxt = (op == OP_ADD) ? sat8(9'(x) + 9'(y)) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en.front[0]) begin
      op_a_r  <= op;
      p_a_r   <= p;
      m0_a_r  <= m0_nxt;
      m1_a_r  <= m1_nxt;
      res_a_r <= res_a_nxt;
    end
  end

  // stage b: scale back by 255
  logic [7:0] d0_nxt, d1_nxt, res_b_nxt;

  always_comb begin
    d0_nxt = div255(m0_a_r);
    d1_nxt = div255(m1_a_r);
    case (op_a_r)
      OP_WADD: res_b_nxt = sat8(9'(d0_nxt) + 9'(d1_nxt));
      OP_MUL:  res_b_nxt = d0_nxt;
      default: res_b_nxt = res_a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.front[1]) begin
      op_b_r  <= op_a_r;
      p_b_r   <= p_a_r;
      d0_b_r  <= d0_nxt;
      d1_b_r  <= d1_nxt;
      res_b_r <= res_b_nxt;
    end
  end

  // stage c: second product
  logic [15:0] m2_nxt;

  always_comb begin
    if (op_b_r == OP_AMUL) begin
      m2_nxt = {8'd0, ~d0_b_r} * {8'd0, ~d1_b_r};
    end else begin
      m2_nxt = 16'(d1_b_r) * {8'd0, ~p_b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en.front[2]) begin
      op_c_r  <= op_b_r;
      d0_c_r  <= d0_b_r;
      m2_c_r  <= m2_nxt;
      res_c_r <= res_b_r;
    end
  end

  // stage d: composite numerator n*255 for the divider
  logic [7:0]  t_nxt, res_d_nxt;
  logic [8:0]  n_nxt;
  logic [16:0] num_wide;
  logic        use_nxt;

  always_comb begin
    t_nxt    = div255(m2_c_r);
    n_nxt    = 9'(d0_c_r) + 9'(t_nxt);
    num_wide = {n_nxt, 8'd0} - 17'(n_nxt);
    use_nxt  = (op_c_r == OP_COMP) && (oa_c != 8'd0);
    case (op_c_r)
      OP_AMUL: res_d_nxt = t_nxt;
      OP_COMP: res_d_nxt = 8'd0;
      default: res_d_nxt = res_c_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.front[3]) begin
      num_d_r <= num_wide[15:0];
      den_d_r <= oa_c;
      use_d_r <= use_nxt;
      res_d_r <= res_d_nxt;
    end
  end

  bld_div u_div (
    .clk     (clk),
    .en      (en.div),
    .num     (num_d_r),
    .den     (den_d_r),
    .use_quo (use_d_r),
    .res     (res_d_r),
    .out_val (out_val)
  );

endmodule

FILE: sv/rgb_blend_unit.sv
// pipeline: an accepted request moves through the arithmetic stages and then the divider
// stages, and its result is taken while out_ready is high
// throughput: one request per cycle while in_ready is high; four arithmetic stages feed a
// four-stage radix-4 divider used by the composite mode
// bubbles collapse: a stage takes new data whenever it is empty or moving on
// reset (synchronous, active low) clears only the stage valid bits
module rgb_blend_unit
  import bld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_a_red,
  input  logic [7:0] in_a_green,
  input  logic [7:0] in_a_blue,
  input  logic [7:0] in_a_weight,
  input  logic [7:0] in_b_red,
  input  logic [7:0] in_b_green,
  input  logic [7:0] in_b_blue,
  input  logic [7:0] in_b_weight,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG:0]   rdy;
  stg_en_t         en;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign en = stg_en_t'(rdy[NSTG-1:0]);

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // output alpha, shared by the three channels
  logic [15:0] mo_a_r;
  logic [7:0]  p_a_r, oa_b_r, oa_c_r;

  always_ff @(posedge clk) begin
    if (en.front[0]) begin
      mo_a_r <= 16'(in_b_weight) * {8'd0, ~in_a_weight};
      p_a_r  <= in_a_weight;
    end
    if (en.front[1]) begin
      oa_b_r <= p_a_r + div255(mo_a_r);
    end
    if (en.front[2]) begin
      oa_c_r <= oa_b_r;
    end
  end

  bld_chan u_red (
    .clk     (clk),
    .en      (en),
    .op      (in_operation),
    .x       (in_a_red),
    .y       (in_b_red),
    .p       (in_a_weight),
    .q       (in_b_weight),
    .oa_c    (oa_c_r),
    .out_val (out_red)
  );

  bld_chan u_green (
    .clk     (clk),
    .en      (en),
    .op      (in_operation),
    .x       (in_a_green),
    .y       (in_b_green),
    .p       (in_a_weight),
    .q       (in_b_weight),
    .oa_c    (oa_c_r),
    .out_val (out_green)
  );

  bld_chan u_blue (
    .clk     (clk),
    .en      (en),
    .op      (in_operation),
    .x       (in_a_blue),
    .y       (in_b_blue),
    .p       (in_a_weight),
    .q       (in_b_weight),
    .oa_c    (oa_c_r),
    .out_val (out_blue)
  );

endmodule

FILE: sv/bld_chk.sv
module bld_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // pipeline comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a free-running output never back-pressures the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red)
      && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  // an empty output stage lets every stage move, so the input stays open
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage empty");

endmodule

bind rgb_blend_unit bld_chk u_chk (.*);

FILE: sim/tb_rgb_blend_unit.sv
module tb_rgb_blend_unit
  import bld_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIXEL_MAX   = 255;
  localparam logic [2:0]  OP_CODE_MAX = 3'd7;
  localparam int          RANDOM_REQS = 1750;
  localparam int          CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] a_red, a_green, a_blue, a_weight;
    logic [7:0] b_red, b_green, b_blue, b_weight;
  } pixel_pair_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] red, green, blue;
  } blended_pixel_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_LONG_STALL
  } rdy_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_operation;
  logic [7:0] in_a_red, in_a_green, in_a_blue, in_a_weight;
  logic [7:0] in_b_red, in_b_green, in_b_blue, in_b_weight;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_red, out_green, out_blue;

  blended_pixel_t expected_pixels[$];
  int             err_cnt = 0;
  int             cycle_cnt = 0;
  int             burst_left = 0;

  rdy_mode_t  ready_mode = RDY_ALWAYS;
  int         ready_phase_left = 100;
  int         stall_left = 0;
  logic [7:0] ready_rot = 8'b1011_0110;

  rgb_blend_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] blend_channel(input logic [2:0] op,
                                               input int unsigned x, y, p, q);
    int unsigned u, v, oa, n, r;
    r = 0;
    case (op)
      OP_ADD:  r = x + y;
      OP_WADD: r = x * p / PIXEL_MAX + y * q / PIXEL_MAX;
      OP_MUL:  r = x * y / PIXEL_MAX;
      OP_AMUL: begin
        u = PIXEL_MAX - (PIXEL_MAX - x) * p / PIXEL_MAX;
        v = PIXEL_MAX - (PIXEL_MAX - y) * q / PIXEL_MAX;
        r = u * v / PIXEL_MAX;
      end
      OP_COMP: begin
        oa = p + q * (PIXEL_MAX - p) / PIXEL_MAX;
        // fully transparent result stays black
        if (oa != 0) begin
          n = x * p / PIXEL_MAX + ((y * q / PIXEL_MAX) * (PIXEL_MAX - p)) / PIXEL_MAX;
          r = n * PIXEL_MAX / oa;
        end
      end
      default: r = 0;
    endcase
    return (r > PIXEL_MAX) ? 8'hFF : r[7:0];
  endfunction

  function automatic blended_pixel_t blend_pixel(input pixel_pair_t px);
    blended_pixel_t res;
    res.op    = px.op;
    res.red   = blend_channel(px.op, 32'(px.a_red), 32'(px.b_red),
                              32'(px.a_weight), 32'(px.b_weight));
    res.green = blend_channel(px.op, 32'(px.a_green), 32'(px.b_green),
                              32'(px.a_weight), 32'(px.b_weight));
    res.blue  = blend_channel(px.op, 32'(px.a_blue), 32'(px.b_blue),
                              32'(px.a_weight), 32'(px.b_weight));
    return res;
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic send_pixel(input logic [2:0] op,
                            input logic [7:0] ar, ag, ab, aw,
                            input logic [7:0] br, bg, bb, bw);
    pixel_pair_t px;
    int gap;
    px = '{op: op, a_red: ar, a_green: ag, a_blue: ab, a_weight: aw,
           b_red: br, b_green: bg, b_blue: bb, b_weight: bw};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1, 2: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 12);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_operation <= px.op;
    in_a_red     <= px.a_red;
    in_a_green   <= px.a_green;
    in_a_blue    <= px.a_blue;
    in_a_weight  <= px.a_weight;
    in_b_red     <= px.b_red;
    in_b_green   <= px.b_green;
    in_b_blue    <= px.b_blue;
    in_b_weight  <= px.b_weight;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(blend_pixel(px));
  endtask

  // hold off new requests until the pipe has fully emptied
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic test_saturating_add();
    send_pixel(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(OP_ADD, 8'd100, 8'd200, 8'd1, 8'd7, 8'd155, 8'd57, 8'd254, 8'd9);
    send_pixel(OP_ADD, 8'd128, 8'd0, 8'd255, 8'd0, 8'd127, 8'd255, 8'd0, 8'd255);
  endtask

  task automatic test_weighted_add();
    send_pixel(OP_WADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(OP_WADD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(OP_WADD, 8'd200, 8'd10, 8'd90, 8'd128, 8'd180, 8'd0, 8'd255, 8'd200);
    send_pixel(OP_WADD, 8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd0, 8'd254, 8'd1);
  endtask

  task automatic test_multiply();
    send_pixel(OP_MUL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(OP_MUL, 8'h00, 8'hFF, 8'd128, 8'hFF, 8'hFF, 8'h00, 8'd2, 8'hFF);
    send_pixel(OP_MUL, 8'd254, 8'd16, 8'd99, 8'd37, 8'd254, 8'd16, 8'd201, 8'd140);
  endtask

  task automatic test_alpha_multiply();
    send_pixel(OP_AMUL, 8'h00, 8'd50, 8'hFF, 8'h00, 8'h00, 8'd77, 8'hFF, 8'h00);
    send_pixel(OP_AMUL, 8'd30, 8'd200, 8'hFF, 8'hFF, 8'd90, 8'd10, 8'hFF, 8'hFF);
    send_pixel(OP_AMUL, 8'h00, 8'h00, 8'h00, 8'd128, 8'h00, 8'h00, 8'h00, 8'd64);
    send_pixel(OP_AMUL, 8'd17, 8'd240, 8'd128, 8'd1, 8'd250, 8'd3, 8'd127, 8'd254);
  endtask

  task automatic test_alpha_composite();
    // zero output alpha: both pixels transparent
    send_pixel(OP_COMP, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(OP_COMP, 8'd10, 8'd128, 8'd250, 8'hFF, 8'd200, 8'd5, 8'd60, 8'd130);
    send_pixel(OP_COMP, 8'd10, 8'd128, 8'd250, 8'h00, 8'd200, 8'd5, 8'd60, 8'hFF);
    send_pixel(OP_COMP, 8'hFF, 8'h00, 8'd77, 8'd1, 8'h00, 8'hFF, 8'd180, 8'd1);
    send_pixel(OP_COMP, 8'd240, 8'd33, 8'hFF, 8'd128, 8'd16, 8'd220, 8'hFF, 8'd100);
  endtask

  task automatic test_undefined_ops();
    for (int k = int'(OP_COMP) + 1; k <= int'(OP_CODE_MAX); k++) begin
      send_pixel(3'(k), 8'hFF, 8'd99, 8'd1, 8'hFF, 8'hFF, 8'd13, 8'd200, 8'hFF);
    end
  endtask

  task automatic test_random_traffic();
    logic [2:0] op;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 15) == 0) op = 3'($urandom_range(0, OP_CODE_MAX));
      else op = 3'($urandom_range(0, OP_COMP));
      send_pixel(op, rand_level(), rand_level(), rand_level(), rand_level(),
                 rand_level(), rand_level(), rand_level(), rand_level());
      if (i % 600 == 599) wait_drained();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    blended_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                  out_red, out_green, out_blue));
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red)
          report_mismatch($sformatf("op %0d red got %0d expected %0d",
                                    want.op, out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("op %0d green got %0d expected %0d",
                                    want.op, out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("op %0d blue got %0d expected %0d",
                                    want.op, out_blue, want.blue));
      end
    end
  end

  // receiver backpressure, switching between a few stall styles
  always @(posedge clk) begin
    if (ready_phase_left == 0) begin
      ready_mode       <= rdy_mode_t'($urandom_range(0, 3));
      ready_phase_left <= $urandom_range(50, 300);
    end else begin
      ready_phase_left <= ready_phase_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      RDY_PATTERN: begin
        out_ready <= ready_rot[0];
        ready_rot <= {ready_rot[0], ready_rot[7:1]};
      end
      default: begin
        if (stall_left > 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          out_ready  <= 1'b0;
          stall_left <= $urandom_range(1, 20);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    out_ready    = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_a_red     = '0;
    in_a_green   = '0;
    in_a_blue    = '0;
    in_a_weight  = '0;
    in_b_red     = '0;
    in_b_green   = '0;
    in_b_blue    = '0;
    in_b_weight  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_saturating_add();
    test_weighted_add();
    test_multiply();
    test_alpha_multiply();
    test_alpha_composite();
    test_undefined_ops();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (2 * NSTG + 4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
